/* rtl/raycast_column_renderer_top_assert.svh */
// Assertion helpers for the column renderer checker.
`ifndef RAYCAST_COLUMN_RENDERER_TOP_ASSERT_SVH
`define RAYCAST_COLUMN_RENDERER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define RCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst.
`define RCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rcr_pkg.sv */
// ----------------------------------------------------------------------------
// rcr_pkg
// Shared constants, types and constant tables of the column renderer.
// ----------------------------------------------------------------------------
package rcr_pkg;

  localparam int MAP_SIZE    = 16;
  localparam int SCREEN_COLS = 120;
  localparam int SCREEN_ROWS = 40;
  localparam int MAX_STEPS   = 160;

  localparam int POS_W   = 12;
  localparam int ANG_W   = 10;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int GLYPH_W = 4;
  localparam int STEPS_W = 8;
  localparam int MAP_W   = 64;
  localparam int MAPB_W  = 256;
  localparam int CIDX_W  = 2;

  // Ray march accumulator: px*640 + dir*k, in 1/163840 of a cell
  localparam int ACC_W    = 24;
  localparam int DIR_W    = 16;
  localparam int SIN_W    = 15;
  localparam int CELL_DEN = 163840;
  localparam int CELL_SH  = 15;
  localparam int CEIL_W   = 12;
  localparam int K_W      = $clog2(MAX_STEPS + 1);

  // Column offset: floor(col*128/SCREEN_COLS) by reciprocal
  localparam int RECIP_SH = 22;
  localparam int RECIP    = ((1 << RECIP_SH) + SCREEN_COLS - 1) / SCREEN_COLS;

  // Glyph codes
  localparam logic [GLYPH_W-1:0] G_BLANK  = 4'd0;
  localparam logic [GLYPH_W-1:0] G_FULL   = 4'd1;
  localparam logic [GLYPH_W-1:0] G_DARK   = 4'd2;
  localparam logic [GLYPH_W-1:0] G_MEDIUM = 4'd3;
  localparam logic [GLYPH_W-1:0] G_LIGHT  = 4'd4;
  localparam logic [GLYPH_W-1:0] G_HASH   = 4'd5;
  localparam logic [GLYPH_W-1:0] G_X      = 4'd6;
  localparam logic [GLYPH_W-1:0] G_DOT    = 4'd7;
  localparam logic [GLYPH_W-1:0] G_DASH   = 4'd8;

  typedef logic [SIN_W-1:0] sine_tab_t [0:256];
  typedef logic signed [CEIL_W-1:0] ceil_tab_t [0:MAX_STEPS];

  // One ray job handed from the front to the back
  typedef struct packed {
    logic [POS_W-1:0]        px;
    logic [POS_W-1:0]        py;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
  } job_t;

  // Unsigned quotient by shift and subtract, used only to build tables
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine in Q1.14 from a Q30 Taylor series
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] den;
    for (int i = 0; i <= 256; i++) begin
      x   = (64'(i) * 64'd3373259426) >> 9;
      sum = x;
      term = x;
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        den  = 64'((2 * n) * (2 * n + 1));
        term = udiv64(term, den);
        if ((n & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
      tab[i] = SIN_W'((sum + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  // Ceiling row for each step count, truncated toward zero
  function automatic ceil_tab_t build_ceil();
    ceil_tab_t   tab;
    logic [63:0] q;
    tab[0] = '0;
    for (int k = 1; k <= MAX_STEPS; k++) begin
      if (k < 20) begin
        q      = udiv64(64'(SCREEN_ROWS * (20 - k)), 64'(2 * k));
        tab[k] = -CEIL_W'(q);
      end else begin
        q      = udiv64(64'(SCREEN_ROWS * (k - 20)), 64'(2 * k));
        tab[k] = CEIL_W'(q);
      end
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();
  localparam ceil_tab_t CEIL_TAB = build_ceil();

endpackage

/* rtl/raycast_column_renderer_top.sv */
// ----------------------------------------------------------------------------
// raycast_column_renderer_top
// Casts one ray per screen column over a 16x16 wall map and streams the
// glyphs of the column's rows.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | player_x player_y view_angle column
//   out     | output    | out_valid/out_stall | row glyph wall_steps last
//   cfg     | input     | cfg_we              | cfg_index cfg_data
//
// The back marches k steps (k = march steps, 1 to 160, one step per cycle
// through the march adders), sets up the column, then emits its 40 rows.
// The front takes the next request while the back works; two jobs queue.
// Reset clears the map registers and all control state.
// An output stall holds the current row and pauses the row sequence.
// ----------------------------------------------------------------------------
module raycast_column_renderer_top
  import rcr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [POS_W-1:0]   player_x,
  input  logic [POS_W-1:0]   player_y,
  input  logic [ANG_W-1:0]   view_angle,
  input  logic [COL_W-1:0]   column,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ROW_W-1:0]   row,
  output logic [GLYPH_W-1:0] glyph,
  output logic [STEPS_W-1:0] wall_steps,
  output logic               last,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [MAP_W-1:0]   cfg_data
);

  logic [MAP_W-1:0]  map_regs [0:3];
  logic [MAPB_W-1:0] map_bits;
  logic              push;
  logic              full;
  logic              pop;
  logic              rd_valid;
  job_t              wr_job;
  job_t              rd_job;

  // Map register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) map_regs[i] <= '0;
    end else if (cfg_we) begin
      map_regs[cfg_index] <= cfg_data;
    end
  end

  assign map_bits = {map_regs[3], map_regs[2], map_regs[1], map_regs[0]};

  rcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .player_x   (player_x),
    .player_y   (player_y),
    .view_angle (view_angle),
    .column     (column),
    .push       (push),
    .wr_job     (wr_job),
    .full       (full)
  );

  rcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (wr_job),
    .full     (full),
    .pop      (pop),
    .rd_valid (rd_valid),
    .rd_job   (rd_job)
  );

  rcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .map_bits   (map_bits),
    .rd_valid   (rd_valid),
    .rd_job     (rd_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row        (row),
    .glyph      (glyph),
    .wall_steps (wall_steps),
    .last       (last)
  );

endmodule

/* rtl/rcr_queue.sv */
// ----------------------------------------------------------------------------
// rcr_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module rcr_queue
  import rcr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output logic rd_valid,
  output job_t rd_job
);

  job_t       slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job   = slots[rd_ptr];

  // Store a job on push
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/rcr_front.sv */
// ----------------------------------------------------------------------------
// rcr_front
// Accepts ray requests, forms the ray angle and looks up its direction.
// ----------------------------------------------------------------------------
module rcr_front
  import rcr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [POS_W-1:0] player_x,
  input  logic [POS_W-1:0] player_y,
  input  logic [ANG_W-1:0] view_angle,
  input  logic [COL_W-1:0] column,
  output logic             push,
  output job_t             wr_job,
  input  logic             full
);

  logic             f_valid;
  logic [POS_W-1:0] f_px;
  logic [POS_W-1:0] f_py;
  logic [ANG_W-1:0] f_ang;
  logic             accept;
  logic [31:0]      off_prod;
  logic [ANG_W-1:0] ang_next;
  logic [ANG_W-1:0] ang_y;

  assign in_stall = f_valid && full;
  assign accept   = in_valid && !in_stall;
  assign push     = f_valid && !full;

  // Column offset across the field of view, then wrap to one turn
  assign off_prod = 32'({column, 7'd0}) * 32'(RECIP);
  assign ang_next = view_angle - ANG_W'(64) + off_prod[RECIP_SH +: ANG_W];
  assign ang_y    = f_ang + ANG_W'(256);

  // Signed Q1.14 wave value of an angle
  function automatic logic signed [DIR_W-1:0] wave(input logic [ANG_W-1:0] a);
    logic [8:0]              idx;
    logic signed [DIR_W-1:0] v;
    idx  = a[8] ? (9'd256 - {1'b0, a[7:0]}) : {1'b0, a[7:0]};
    v    = DIR_W'(SINE_TAB[idx]);
    return a[9] ? -v : v;
  endfunction

  assign wr_job.px = f_px;
  assign wr_job.py = f_py;
  assign wr_job.dx = wave(f_ang);
  assign wr_job.dy = wave(ang_y);

  // Hold a request until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= accept || (f_valid && !push);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_px  <= player_x;
      f_py  <= player_y;
      f_ang <= ang_next;
    end
  end

endmodule

/* rtl/rcr_back.sv */
// ----------------------------------------------------------------------------
// rcr_back
// Marches one ray over the map, then emits the glyph of every screen row.
// ----------------------------------------------------------------------------
module rcr_back
  import rcr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [MAPB_W-1:0]  map_bits,
  input  logic               rd_valid,
  input  job_t               rd_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ROW_W-1:0]   row,
  output logic [GLYPH_W-1:0] glyph,
  output logic [STEPS_W-1:0] wall_steps,
  output logic               last
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MARCH = 2'd1;
  localparam logic [1:0] ST_PREP  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic signed [ACC_W-1:0] ACC_LOW  = ACC_W'(-CELL_DEN);
  localparam logic signed [ACC_W-1:0] ACC_HIGH = ACC_W'(MAP_SIZE * CELL_DEN);

  logic [1:0]                state;
  logic [K_W-1:0]            k;
  logic signed [ACC_W-1:0]   acc_x;
  logic signed [ACC_W-1:0]   acc_y;
  logic signed [DIR_W-1:0]   dx;
  logic signed [DIR_W-1:0]   dy;
  logic [K_W-1:0]            steps;
  logic signed [CEIL_W-1:0]  ceil_row;
  logic [GLYPH_W-1:0]        shade;
  logic [ROW_W-1:0]          row_cnt;
  logic signed [ACC_W-1:0]   base_x;
  logic signed [ACC_W-1:0]   base_y;
  logic                      off_map;
  logic [3:0]                cell_x;
  logic [3:0]                cell_y;
  logic                      hit;
  logic                      load_out;
  logic [GLYPH_W-1:0]        row_glyph;
  logic [GLYPH_W-1:0]        shade_next;
  logic [GLYPH_W-1:0]        floor_glyph;
  logic signed [CEIL_W-1:0]  y_s;
  logic signed [CEIL_W-1:0]  floor_row;
  logic [ROW_W:0]            t;
  logic [K_W+1:0]            s_ext;

  // Cell index of a march coordinate known to lie on the map
  function automatic logic [3:0] cell_of(input logic signed [ACC_W-1:0] a);
    logic [6:0]  q;
    logic [14:0] p;
    q = a[CELL_SH +: 7];
    p = 15'(q) * 15'd205;
    return a[ACC_W-1] ? 4'd0 : p[13:10];
  endfunction

  assign base_x  = ACC_W'({rd_job.px, 9'd0}) + ACC_W'({rd_job.px, 7'd0});
  assign base_y  = ACC_W'({rd_job.py, 9'd0}) + ACC_W'({rd_job.py, 7'd0});
  assign off_map = (acc_x <= ACC_LOW) || (acc_x >= ACC_HIGH) ||
                   (acc_y <= ACC_LOW) || (acc_y >= ACC_HIGH);
  assign cell_x  = cell_of(acc_x);
  assign cell_y  = cell_of(acc_y);
  assign hit     = map_bits[{cell_y, cell_x}];
  assign pop     = (state == ST_IDLE) && rd_valid;

  // Wall shade by distance band
  assign s_ext = (K_W + 2)'(steps);
  always_comb begin
    if ((s_ext << 2) <= (K_W + 2)'(MAX_STEPS)) shade_next = G_FULL;
    else if (s_ext * 3 < (K_W + 2)'(MAX_STEPS)) shade_next = G_DARK;
    else if ((s_ext << 1) < (K_W + 2)'(MAX_STEPS)) shade_next = G_MEDIUM;
    else if (s_ext < (K_W + 2)'(MAX_STEPS)) shade_next = G_LIGHT;
    else shade_next = G_BLANK;
  end

  // Floor shade by distance from the bottom
  assign t = (ROW_W + 1)'(SCREEN_ROWS) - (ROW_W + 1)'(row_cnt);
  always_comb begin
    if (10'(t) * 10'd8 < 10'(SCREEN_ROWS)) floor_glyph = G_HASH;
    else if (10'(t) * 10'd4 < 10'(SCREEN_ROWS)) floor_glyph = G_X;
    else if (10'(t) * 10'd8 < 10'(3 * SCREEN_ROWS)) floor_glyph = G_DOT;
    else if (12'(t) * 12'd20 < 12'(9 * SCREEN_ROWS)) floor_glyph = G_DASH;
    else floor_glyph = G_BLANK;
  end

  // Glyph of the current row
  assign y_s       = CEIL_W'(row_cnt);
  assign floor_row = CEIL_W'(SCREEN_ROWS) - ceil_row;
  always_comb begin
    if (y_s < ceil_row) row_glyph = G_BLANK;
    else if (y_s > ceil_row && y_s <= floor_row) row_glyph = shade;
    else row_glyph = floor_glyph;
  end

  assign load_out = (state == ST_EMIT) && (!out_valid || !out_stall);

  // Sequence march, setup and row emission
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (rd_valid) state <= ST_MARCH;
        end
        ST_MARCH: begin
          if (off_map || hit || k == K_W'(MAX_STEPS)) state <= ST_PREP;
        end
        ST_PREP: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load_out && row_cnt == ROW_W'(SCREEN_ROWS - 1)) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // March and row datapath: one step of a tenth of a cell per cycle while marching
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dx    <= rd_job.dx;
        dy    <= rd_job.dy;
        acc_x <= base_x + ACC_W'(rd_job.dx);
        acc_y <= base_y + ACC_W'(rd_job.dy);
        k     <= K_W'(1);
      end
      ST_MARCH: begin
        if (off_map) steps <= K_W'(MAX_STEPS);
        else steps <= k;
        k     <= k + K_W'(1);
        acc_x <= acc_x + ACC_W'(dx);
        acc_y <= acc_y + ACC_W'(dy);
      end
      ST_PREP: begin
        ceil_row <= CEIL_TAB[steps];
        shade    <= shade_next;
        row_cnt  <= '0;
      end
      ST_EMIT: begin
        if (load_out) row_cnt <= row_cnt + ROW_W'(1);
      end
      default: ;
    endcase
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      row        <= row_cnt;
      glyph      <= row_glyph;
      wall_steps <= STEPS_W'(steps);
      last       <= (row_cnt == ROW_W'(SCREEN_ROWS - 1));
    end
  end

endmodule

/* rtl/rcr_checker.sv */
// ----------------------------------------------------------------------------
// rcr_checker
// Port-level checks of the column renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "raycast_column_renderer_top_assert.svh"

module rcr_checker
  import rcr_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [ROW_W-1:0]   row,
  input logic [GLYPH_W-1:0] glyph,
  input logic [STEPS_W-1:0] wall_steps,
  input logic               last
);

  // A stalled row stays offered
  `RCR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable({row, glyph, wall_steps, last}), "stalled row dropped")

  // Rows of a column follow without a gap
  `RCR_ASSERT_NEXT(a_row_next, out_valid && !out_stall && !last,
    out_valid && row == $past(row) + ROW_W'(1), "row sequence broken")

  // last marks exactly the bottom row
  `RCR_ASSERT_NOW(a_last_row, out_valid,
    last == (row == ROW_W'(SCREEN_ROWS - 1)), "last flag off bottom row")

  // Distance stays within the march range
  `RCR_ASSERT_NOW(a_steps_rng, out_valid,
    wall_steps != '0 && wall_steps <= STEPS_W'(MAX_STEPS), "distance out of range")

endmodule

bind raycast_column_renderer_top rcr_checker u_rcr_checker (.*);
